// ----- rtl/q24_pkg.sv -----
package q24_pkg;

    localparam int FracBits = 8;
    localparam int DataW    = 32;
    // Dividend magnitude is |a| << FracBits: DataW + FracBits bits.
    localparam int DivW     = DataW + FracBits;
    // One divider cell per quotient bit.
    localparam int NumCells = DivW;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_MIN      = 4'd4,
        ACT_MAX      = 4'd5,
        ACT_INC      = 4'd6,
        ACT_DEC      = 4'd7,
        ACT_FROM_INT = 4'd8,
        ACT_TO_INT   = 4'd9
    } t_action;

    typedef struct packed {
        logic [3:0]        action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               divide_by_zero;
    } t_out_item;

    // Everything that travels down the chain beside the division.
    typedef struct packed {
        logic              vld;
        logic              is_div;
        logic              neg;
        logic [DataW-1:0]  early;   // result for all non-divide actions
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
    } t_side;

    // Per-cell restoring division state.
    typedef struct packed {
        logic [DivW-1:0]   rem;
        logic [DivW-1:0]   quo;     // remaining dividend bits shift out, quotient in
        logic [DataW-1:0]  dsr;
    } t_div;

endpackage

// ----- rtl/q24_cell.sv -----
module q24_cell
    import q24_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_side i_side,
    input  t_div  i_div,
    output t_side o_side,
    output t_div  o_div
);

    t_side r_side;
    t_div  r_div;
    logic [DivW:0] trial;
    logic [DivW:0] diff;
    t_div  n_div;

    always_comb begin
        trial = {i_div.rem, i_div.quo[DivW-1]};
        diff  = trial - {{(DivW-DataW+1){1'b0}}, i_div.dsr};
        n_div.dsr = i_div.dsr;
        if (!diff[DivW]) begin
            n_div.rem = diff[DivW-1:0];
        end else begin
            n_div.rem = trial[DivW-1:0];
        end
        n_div.quo = {i_div.quo[DivW-2:0], ~diff[DivW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side.vld <= i_side.vld;
        end
        r_side.is_div <= i_side.is_div;
        r_side.neg    <= i_side.neg;
        r_side.early  <= i_side.early;
        r_side.lt     <= i_side.lt;
        r_side.eq     <= i_side.eq;
        r_side.gt     <= i_side.gt;
        r_side.dz     <= i_side.dz;
        r_div         <= n_div;
    end

    assign o_side = r_side;
    assign o_div  = r_div;

endmodule

// ----- rtl/q24_front.sv -----
module q24_front
    import q24_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_vld,
    input  t_in_item i_item,
    output t_side    o_side,
    output t_div     o_div
);

    logic signed [31:0] a, b;
    logic signed [63:0] prod;
    logic [63:0]        psh;
    logic [DataW-1:0]   mag_a, mag_b, ti;
    logic [DataW-1:0]   res;
    logic               lt;
    t_side r_side;
    t_div  r_div;

    assign a = i_item.operand_a;
    assign b = i_item.operand_b;
    assign lt = a < b;
    assign mag_a = a[31] ? DataW'(-a) : DataW'(a);
    assign mag_b = b[31] ? DataW'(-b) : DataW'(b);
    assign prod = a * b;
    assign psh  = 64'(prod >>> FracBits);
    assign ti   = DataW'((33'(mag_a) + 33'(1 << (FracBits - 1))) >> FracBits);

    always_comb begin
        unique case (i_item.action)
            ACT_ADD:      res = a + b;
            ACT_SUB:      res = a - b;
            ACT_MUL:      res = psh[31:0];
            ACT_MIN:      res = lt ? a : b;
            ACT_MAX:      res = (a > b) ? a : b;
            ACT_INC:      res = a + 32'sd1;
            ACT_DEC:      res = a - 32'sd1;
            ACT_FROM_INT: res = a <<< FracBits;
            ACT_TO_INT:   res = a[31] ? -ti : ti;
            default:      res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side.vld <= i_vld;
        end
        r_side.is_div <= i_item.action == ACT_DIV;
        r_side.neg    <= a[31] ^ b[31];
        r_side.early  <= res;
        r_side.lt     <= lt;
        r_side.eq     <= a == b;
        r_side.gt     <= a > b;
        r_side.dz     <= (i_item.action == ACT_DIV) && (b == 32'sd0);
        r_div.rem     <= '0;
        r_div.quo     <= {mag_a, {FracBits{1'b0}}};
        r_div.dsr     <= mag_b;
    end

    assign o_side = r_side;
    assign o_div  = r_div;

endmodule

// ----- rtl/q24_24_8_fixed_point_alu_dummy.sv -----
module q24_tail
    import q24_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_side     i_side,
    input  t_div      i_div,
    output logic      o_strobe,
    output t_out_item o_item
);

    logic [DataW-1:0] q;
    logic [DataW-1:0] val;
    logic             r_strobe;
    t_out_item        r_item;

    always_comb begin
        q = i_div.quo[DataW-1:0];
        if (!i_side.is_div) begin
            val = i_side.early;
        end else if (i_side.dz) begin
            val = '0;
        end else begin
            val = i_side.neg ? -q : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_side.vld;
        end
        r_item.result_value   <= val;
        r_item.a_less         <= i_side.lt;
        r_item.a_equal        <= i_side.eq;
        r_item.a_greater      <= i_side.gt;
        r_item.divide_by_zero <= i_side.dz;
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;

`ifndef SYNTHESIS
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $onehot({r_item.a_less, r_item.a_equal, r_item.a_greater}))
        else $error("comparison flags not one-hot");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_item.divide_by_zero) |-> (r_item.result_value == 32'sd0))
        else $error("divide by zero gave non-zero result");
    a_dz_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_side.vld && i_side.dz) |-> i_side.is_div)
        else $error("zero-divisor flag outside divide");
`endif

endmodule

// ----- rtl/q24_8_fixed_point_alu.sv -----
// Channel   Ports                         Handshake
// -------   ----------------------------  -----------------------------
// command   i_start, o_busy, i_cmd        transfer when i_start && !o_busy
// result    o_done, o_result              one cycle, no back-pressure
//
// One item is taken every cycle; o_busy is held low at all times.
// Every result follows its transfer in order through a front stage, one
// divider cell per quotient bit, and a result register. All actions take
// the same path length so results never overtake one another. Synchronous
// active-low reset drops all in-flight items; the receiver cannot stall.
module q24_8_fixed_point_alu
    import q24_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_cmd,
    output logic      o_done,
    output t_out_item o_result
);

    t_side side [NumCells+1];
    t_div  dv   [NumCells+1];

    assign o_busy = 1'b0;

    // Decode, compute all non-divide actions, and seed the divider.
    q24_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_item  (i_cmd),
        .o_side  (side[0]),
        .o_div   (dv[0])
    );

    // Restoring division chain: each cell retires one quotient bit.
    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        q24_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (side[g]),
            .i_div   (dv[g]),
            .o_side  (side[g+1]),
            .o_div   (dv[g+1])
        );
    end

    // Apply sign, select result, and register the outgoing transfer.
    q24_tail u_tail (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_side   (side[NumCells]),
        .i_div    (dv[NumCells]),
        .o_strobe (o_done),
        .o_item   (o_result)
    );

endmodule

// ----- dv/q24_8_fixed_point_alu_test.sv -----
`timescale 1ns / 1ps

module q24_8_fixed_point_alu_test;
    import q24_pkg::*;

    localparam int  ClkPeriod  = 8;
    localparam int  Latency    = NumCells + 2;
    localparam int  CycleLimit = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_cmd;
    logic      o_done;
    t_out_item o_result;

    t_out_item alu_expected[$];
    int        fail_count;
    int        cycle_count;
    bit        idle_enable;

    q24_8_fixed_point_alu uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    // Work out the result of one operation at the unit's own widths.
    function automatic t_out_item alu_predict(t_in_item cmd);
        t_out_item          res;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
        logic [63:0]        mag_a;
        logic [63:0]        mag_b;
        logic [63:0]        quo;
        a = cmd.operand_a;
        b = cmd.operand_b;
        mag_a = a[31] ? 64'(-64'(a)) : 64'(a);
        mag_b = b[31] ? 64'(-64'(b)) : 64'(b);
        res = '0;
        case (cmd.action)
            ACT_ADD: res.result_value = a + b;
            ACT_SUB: res.result_value = a - b;
            ACT_MUL: begin
                prod = 64'(a) * 64'(b);
                res.result_value = 32'(prod >>> FracBits);
            end
            ACT_DIV: begin
                if (b == 0) begin
                    res.divide_by_zero = 1'b1;
                end else begin
                    quo = (mag_a << FracBits) / mag_b;
                    res.result_value = (a[31] ^ b[31]) ? 32'(-quo) : 32'(quo);
                end
            end
            ACT_MIN: res.result_value = (a < b) ? a : b;
            ACT_MAX: res.result_value = (a > b) ? a : b;
            ACT_INC: res.result_value = a + 1;
            ACT_DEC: res.result_value = a - 1;
            ACT_FROM_INT: res.result_value = a << FracBits;
            ACT_TO_INT: begin
                // Round half away from zero on the magnitude, then restore the sign.
                quo = (mag_a + (64'd1 << (FracBits - 1))) >> FracBits;
                res.result_value = a[31] ? 32'(-quo) : 32'(quo);
            end
            default: res.result_value = '0;
        endcase
        res.a_less    = a < b;
        res.a_equal   = a == b;
        res.a_greater = a > b;
        return res;
    endfunction

    // Offer one operation; hold start until the unit takes the transfer.
    task automatic send_op(input logic [3:0] act, input logic [31:0] a,
                           input logic [31:0] b);
        t_in_item cmd;
        cmd.action    = act;
        cmd.operand_a = a;
        cmd.operand_b = b;
        // Insert random gaps in front of the transfer.
        while (idle_enable && $urandom_range(99) < 28) begin
            i_start <= 1'b0;
            i_cmd   <= t_in_item'({$urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        alu_expected.push_back(alu_predict(cmd));
    endtask

    task automatic drop_start;
        i_start <= 1'b0;
    endtask

    task automatic wait_drain;
        drop_start();
        while (alu_expected.size() != 0) @(posedge i_clk);
    endtask

    // Compare every result against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (alu_expected.size() == 0) begin
                $error("unexpected result %h", o_result);
                fail_count++;
            end else begin
                want = alu_expected.pop_front();
                if (o_result.result_value !== want.result_value) begin
                    $error("result_value expected %h got %h",
                           want.result_value, o_result.result_value);
                    fail_count++;
                end
                if (o_result.a_less !== want.a_less) begin
                    $error("a_less expected %b got %b", want.a_less, o_result.a_less);
                    fail_count++;
                end
                if (o_result.a_equal !== want.a_equal) begin
                    $error("a_equal expected %b got %b", want.a_equal, o_result.a_equal);
                    fail_count++;
                end
                if (o_result.a_greater !== want.a_greater) begin
                    $error("a_greater expected %b got %b",
                           want.a_greater, o_result.a_greater);
                    fail_count++;
                end
                if (o_result.divide_by_zero !== want.divide_by_zero) begin
                    $error("divide_by_zero expected %b got %b",
                           want.divide_by_zero, o_result.divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return 32'($signed($urandom_range(1024)) - 512);
            3: return 32'($signed($urandom_range(65536)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    // Extremes, every action, rounding ties, zero divisor, unknown codes.
    task automatic test_directed;
        send_op(ACT_ADD, 32'h7fff_ffff, 32'd1);
        send_op(ACT_SUB, 32'h8000_0000, 32'd1);
        send_op(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(ACT_MUL, 32'hffff_ff80, 32'd1);
        send_op(ACT_DIV, 32'd256, 32'd0);
        send_op(ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(ACT_DIV, 32'hffff_fd00, 32'd512);
        send_op(ACT_MIN, 32'h8000_0000, 32'h7fff_ffff);
        send_op(ACT_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_op(ACT_MIN, 32'd5, 32'd5);
        send_op(ACT_INC, 32'h7fff_ffff, 32'd0);
        send_op(ACT_DEC, 32'h8000_0000, 32'd0);
        send_op(ACT_FROM_INT, 32'h0080_0000, 32'd3);
        send_op(ACT_FROM_INT, 32'hffff_ffff, 32'hffff_ffff);
        send_op(ACT_TO_INT, 32'h0000_0180, 32'd0);
        send_op(ACT_TO_INT, 32'hffff_fe80, 32'd0);
        send_op(ACT_TO_INT, 32'h0000_017f, 32'd0);
        send_op(ACT_TO_INT, 32'h8000_0000, 32'd0);
        send_op(ACT_TO_INT, 32'h7fff_ffff, 32'd0);
        send_op(4'd10, 32'd1, 32'd2);
        send_op(4'd15, 32'hffff_ffff, 32'h0);
        drop_start();
    endtask

    // Random mix; stop for a full drain half way through.
    task automatic test_random(input int n);
        logic [3:0] act;
        for (int k = 0; k < n; k++) begin
            // Leave a long burst without gaps.
            idle_enable = !(k >= 300 && k < 600);
            act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                             : 4'($urandom_range(9));
            if (act == ACT_DIV && $urandom_range(9) == 0)
                send_op(act, pick_operand(), 32'd0);
            else if ($urandom_range(15) == 0)
                send_op(act, pick_operand(), pick_operand() & 32'h0000_00ff);
            else begin
                logic [31:0] a;
                a = pick_operand();
                send_op(act, a, ($urandom_range(9) == 0) ? a : pick_operand());
            end
            if (k == n / 2) wait_drain();
        end
        idle_enable = 1'b1;
        drop_start();
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(1530);
        wait_drain();
        repeat (Latency + 10) @(posedge i_clk);

        if (fail_count == 0 && alu_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
